FILE: design/dedup_weighted_two_level_queue_macros.svh
// Assertion macros for the weighted two-level queue.
`ifndef DEDUP_WEIGHTED_TWO_LEVEL_QUEUE_MACROS_SVH
`define DEDUP_WEIGHTED_TWO_LEVEL_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge
`define DWQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
// property checked in the cycle after its trigger
`define DWQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence violated");
`else
`define DWQ_ASSERT_ALWAYS(lbl, expr)
`define DWQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/dwq_pkg.sv
// Shared types and constants of the weighted two-level queue.
package dwq_pkg;

  // default geometry
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 32;

  // register map
  localparam int        CFG_DATA_W     = 32;
  localparam int        CFG_ADDR_W     = 3;
  localparam logic      REG_HIGH_SHARE = 1'b0;
  localparam logic [3:0] HIGH_SHARE_RST = 4'd9;

  // request codes
  typedef enum logic [1:0] {
    FN_ENQ_HIGH = 2'd0,
    FN_ENQ_LOW  = 2'd1,
    FN_DEQ      = 2'd2
  } func_t;

  // result codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DEQ  = 3'b100
  } state_t;

endpackage

FILE: design/dedup_weighted_two_level_queue.sv
// Top level of the deduplicating weighted two-level queue.
// Enqueue: a key scan over both queues, then the result; the key
// scan reads one entry of each queue memory per cycle. Dequeue: one memory
// read, then the rotating write-back. Func 3 and empty dequeue answer from idle.
// One word in flight; the next is accepted the cycle its result is taken or after.
// Synchronous reset clears heads, counts, pattern counter, high_share (to 9); the key
// stores are not cleared and need no clearing pass.
`include "dedup_weighted_two_level_queue_macros.svh"

module dedup_weighted_two_level_queue #(
  parameter int QUEUE_DEPTH = dwq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_WIDTH   = dwq_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dwq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dwq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [KEY_WIDTH-1:0]            in_item_key,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [KEY_WIDTH-1:0]            out_key,
  output logic                            out_from_high
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // ring pointer step with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) q = '0;
    else q = p + 1'b1;
    return q;
  endfunction

  // tail slot: head + count, which stays below twice the depth
  function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] h,
                                               input logic [CNT_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(c);
    if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  dwq_pkg::state_t state_r, state_nxt;

  logic [1:0]           func_r, func_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [PTR_W-1:0]     hp_r, hp_nxt, lp_r, lp_nxt;
  logic                 hvld_r, lvld_r;
  logic                 dup_r, dup_nxt;
  logic                 sel_high_r, sel_high_nxt;

  logic [PTR_W-1:0] high_head_r, high_head_nxt, low_head_r, low_head_nxt;
  logic [CNT_W-1:0] high_count_r, high_count_nxt, low_count_r, low_count_nxt;
  logic [3:0]       pattern_r, pattern_nxt;
  logic [3:0]       high_share_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [KEY_WIDTH-1:0] out_key_r, out_key_nxt;
  logic                 out_from_high_r, out_from_high_nxt;

  // key stores
  logic [KEY_WIDTH-1:0] high_mem [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0] low_mem  [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0] h_rdata_r, l_rdata_r;
  logic [PTR_W-1:0]     h_raddr, l_raddr, h_waddr, l_waddr;
  logic                 h_we, l_we;
  logic [KEY_WIDTH-1:0] h_wdata, l_wdata;

  logic in_fire, h_issue, l_issue, match_now, dup_final;
  logic prefer_high, take_high, tgt_high;
  logic [CNT_W-1:0]     tgt_count;
  logic [KEY_WIDTH-1:0] deq_key;

  // configuration register
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == dwq_pkg::REG_HIGH_SHARE) prdata[3:0] = high_share_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_share_r <= dwq_pkg::HIGH_SHARE_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dwq_pkg::REG_HIGH_SHARE) begin
      high_share_r <= pwdata[3:0];
    end
  end

  // handshake
  assign in_ready      = (state_r == dwq_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_from_high = out_from_high_r;

  // scan issue and compare of the previous cycle's read data
  assign h_issue   = (state_r == dwq_pkg::ST_SCAN) && (idx_r < high_count_r);
  assign l_issue   = (state_r == dwq_pkg::ST_SCAN) && (idx_r < low_count_r);
  assign match_now = (hvld_r && h_rdata_r == key_r) || (lvld_r && l_rdata_r == key_r);
  assign dup_final = dup_r || match_now;

  assign h_raddr = (state_r == dwq_pkg::ST_SCAN) ? hp_r : high_head_r;
  assign l_raddr = (state_r == dwq_pkg::ST_SCAN) ? lp_r : low_head_r;

  // weighted choice of the queue to take from
  assign prefer_high = pattern_r < high_share_r;
  assign take_high   = prefer_high ? (high_count_r != '0) : (low_count_r == '0);
  assign tgt_high    = (func_r == dwq_pkg::FN_ENQ_HIGH);
  assign tgt_count   = tgt_high ? high_count_r : low_count_r;
  assign deq_key     = sel_high_r ? h_rdata_r : l_rdata_r;

  // controller
  always_comb begin
    state_nxt         = state_r;
    func_nxt          = func_r;
    key_nxt           = key_r;
    idx_nxt           = idx_r;
    hp_nxt            = hp_r;
    lp_nxt            = lp_r;
    dup_nxt           = dup_r;
    sel_high_nxt      = sel_high_r;
    high_head_nxt     = high_head_r;
    low_head_nxt      = low_head_r;
    high_count_nxt    = high_count_r;
    low_count_nxt     = low_count_r;
    pattern_nxt       = pattern_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_key_nxt       = out_key_r;
    out_from_high_nxt = out_from_high_r;
    h_we              = 1'b0;
    l_we              = 1'b0;
    h_waddr           = tail_of(high_head_r, high_count_r);
    l_waddr           = tail_of(low_head_r, low_count_r);
    h_wdata           = key_r;
    l_wdata           = key_r;

    unique case (state_r)
      dwq_pkg::ST_IDLE: begin
        if (in_fire) begin
          func_nxt = in_func;
          key_nxt  = in_item_key;
          unique case (in_func)
            dwq_pkg::FN_ENQ_HIGH, dwq_pkg::FN_ENQ_LOW: begin
              idx_nxt   = '0;
              hp_nxt    = high_head_r;
              lp_nxt    = low_head_r;
              dup_nxt   = 1'b0;
              state_nxt = dwq_pkg::ST_SCAN;
            end
            dwq_pkg::FN_DEQ: begin
              if (high_count_r == '0 && low_count_r == '0) begin
                out_valid_nxt     = 1'b1;
                out_status_nxt    = dwq_pkg::STAT_EMPTY;
                out_key_nxt       = '0;
                out_from_high_nxt = 1'b0;
              end else begin
                // head read is under way this cycle
                sel_high_nxt = take_high;
                state_nxt    = dwq_pkg::ST_DEQ;
              end
            end
            default: begin
              out_valid_nxt     = 1'b1;
              out_status_nxt    = dwq_pkg::STAT_OK;
              out_key_nxt       = '0;
              out_from_high_nxt = 1'b0;
            end
          endcase
        end
      end

      dwq_pkg::ST_SCAN: begin
        dup_nxt = dup_final;
        if (h_issue || l_issue) begin
          idx_nxt = idx_r + 1'b1;
          hp_nxt  = ptr_inc(hp_r);
          lp_nxt  = ptr_inc(lp_r);
        end else begin
          // walk done: decide, and append unless duplicate or full
          out_valid_nxt     = 1'b1;
          out_key_nxt       = '0;
          out_from_high_nxt = 1'b0;
          state_nxt         = dwq_pkg::ST_IDLE;
          if (dup_final) begin
            out_status_nxt = dwq_pkg::STAT_DUP;
          end else if (tgt_count >= CNT_W'(QUEUE_DEPTH)) begin
            out_status_nxt = dwq_pkg::STAT_FULL;
          end else begin
            out_status_nxt = dwq_pkg::STAT_OK;
            if (tgt_high) begin
              h_we           = 1'b1;
              high_count_nxt = high_count_r + 1'b1;
            end else begin
              l_we          = 1'b1;
              low_count_nxt = low_count_r + 1'b1;
            end
          end
        end
      end

      dwq_pkg::ST_DEQ: begin
        // rotate: head key goes back to the tail
        h_wdata = deq_key;
        l_wdata = deq_key;
        if (sel_high_r) begin
          h_we          = 1'b1;
          high_head_nxt = ptr_inc(high_head_r);
        end else begin
          l_we         = 1'b1;
          low_head_nxt = ptr_inc(low_head_r);
        end
        if (pattern_r >= high_share_r) pattern_nxt = '0;
        else pattern_nxt = pattern_r + 1'b1;
        out_valid_nxt     = 1'b1;
        out_status_nxt    = dwq_pkg::STAT_OK;
        out_key_nxt       = deq_key;
        out_from_high_nxt = sel_high_r;
        state_nxt         = dwq_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = dwq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dwq_pkg::ST_IDLE;
      high_head_r  <= '0;
      low_head_r   <= '0;
      high_count_r <= '0;
      low_count_r  <= '0;
      pattern_r    <= '0;
      out_valid_r  <= 1'b0;
      hvld_r       <= 1'b0;
      lvld_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      high_head_r  <= high_head_nxt;
      low_head_r   <= low_head_nxt;
      high_count_r <= high_count_nxt;
      low_count_r  <= low_count_nxt;
      pattern_r    <= pattern_nxt;
      out_valid_r  <= out_valid_nxt;
      hvld_r       <= h_issue;
      lvld_r       <= l_issue;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r          <= func_nxt;
    key_r           <= key_nxt;
    idx_r           <= idx_nxt;
    hp_r            <= hp_nxt;
    lp_r            <= lp_nxt;
    dup_r           <= dup_nxt;
    sel_high_r      <= sel_high_nxt;
    out_status_r    <= out_status_nxt;
    out_key_r       <= out_key_nxt;
    out_from_high_r <= out_from_high_nxt;
  end

  // key memories, one read and one write port each
  always_ff @(posedge clk) begin
    if (h_we) high_mem[h_waddr] <= h_wdata;
    h_rdata_r <= high_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) low_mem[l_waddr] <= l_wdata;
    l_rdata_r <= low_mem[l_raddr];
  end

  // checks
  `DWQ_ASSERT_ALWAYS(a_high_count_bound, high_count_r <= CNT_W'(QUEUE_DEPTH))
  `DWQ_ASSERT_ALWAYS(a_low_count_bound, low_count_r <= CNT_W'(QUEUE_DEPTH))
  `DWQ_ASSERT_ALWAYS(a_single_word, state_r == dwq_pkg::ST_IDLE || !out_valid_r)
  `DWQ_ASSERT_NEXT(a_accept_moves, in_fire, state_r != dwq_pkg::ST_IDLE || out_valid_r)
  `DWQ_ASSERT_NEXT(a_deq_keeps_count, state_r == dwq_pkg::ST_DEQ, $stable(high_count_r) && $stable(low_count_r))

endmodule
